FILE: design/zpola_pkg.sv
`default_nettype none

package zpola_pkg;

  // fixed field and register widths
  localparam int SAMPLE_W = 16;
  localparam int ACC_W    = 20;
  localparam int VALUE_W  = 24;
  localparam int GAIN_W   = 16;
  localparam int LEN_W    = 12;
  localparam int CFG_W    = 16;
  localparam int CFG_IW   = 2;
  localparam int PROD_W   = ACC_W + GAIN_W + 1;

  // result queue
  localparam int OUTQ_DEPTH = 4;
  localparam int OUTQ_AW    = $clog2(OUTQ_DEPTH);
  localparam int OUTQ_CW    = $clog2(OUTQ_DEPTH + 1);

  // command codes
  localparam logic CMD_PUSH = 1'b0;
  localparam logic CMD_PULL = 1'b1;

  // configuration register indexes
  typedef enum logic [CFG_IW-1:0] {
    REG_FRAME_SIZE = 2'd0,
    REG_HOP_SIZE   = 2'd1,
    REG_NORM_GAIN  = 2'd2
  } reg_index_t;

  typedef struct packed {
    logic                       command;
    logic signed [SAMPLE_W-1:0] sample;
  } cmd_item_t;

  typedef struct packed {
    logic signed [VALUE_W-1:0] value;
    logic                      last;
  } res_item_t;

endpackage

`default_nettype wire

FILE: design/zpola_store.sv
`default_nettype none

// accumulation store: one write and one read port, registered read data,
// bypass of the write that lands on the same edge as the read, clearing pass
module zpola_store
  import zpola_pkg::*;
#(
  parameter int FRAME_MAX = 2048
) (
  input  wire logic                    clk,
  input  wire logic                    rst,
  output logic                         busy,
  input  wire logic [$clog2(FRAME_MAX)-1:0] rd_addr,
  input  wire logic                    wr_en,
  input  wire logic [$clog2(FRAME_MAX)-1:0] wr_addr,
  input  wire logic signed [ACC_W-1:0] wr_data,
  output logic signed [ACC_W-1:0]      rd_data
);

  localparam int AW = $clog2(FRAME_MAX);

  logic [ACC_W-1:0]        mem [FRAME_MAX];
  logic                    clearing;
  logic [AW-1:0]           clr_addr;
  logic                    we;
  logic [AW-1:0]           waddr;
  logic [ACC_W-1:0]        wdata;
  logic [ACC_W-1:0]        ram_q;
  logic                    fwd_hit;
  logic [ACC_W-1:0]        fwd_data;

  assign busy  = clearing;
  assign we    = clearing | wr_en;
  assign waddr = clearing ? clr_addr : wr_addr;
  assign wdata = clearing ? '0 : wr_data;

  // clearing sweep after reset, one entry a cycle
  always_ff @(posedge clk) begin
    if (rst) begin
      clearing <= 1'b1;
      clr_addr <= '0;
    end else if (clearing) begin
      if (clr_addr == AW'(FRAME_MAX - 1)) begin
        clearing <= 1'b0;
      end
      clr_addr <= clr_addr + 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    ram_q <= mem[rd_addr];
  end

  // same-edge write wins over the stale read
  always_ff @(posedge clk) begin
    fwd_hit  <= we && (waddr == rd_addr);
    fwd_data <= wdata;
  end

  assign rd_data = fwd_hit ? $signed(fwd_data) : $signed(ram_q);

endmodule

`default_nettype wire

FILE: design/zpola_scale.sv
`default_nettype none

// gain multiply, round half up, saturate to the result width
module zpola_scale
  import zpola_pkg::*;
(
  input  wire logic                    clk,
  input  wire logic                    rst,
  input  wire logic                    in_valid,
  input  wire logic signed [ACC_W-1:0] acc,
  input  wire logic [GAIN_W-1:0]       gain,
  input  wire logic                    last,
  output logic                         busy,
  output logic                         out_valid,
  output res_item_t                    out_item
);

  localparam int Q_W = PROD_W - 8;

  logic                     prod_valid;
  logic signed [PROD_W-1:0] prod;
  logic                     prod_last;
  logic signed [PROD_W-1:0] rounded;
  logic signed [Q_W-1:0]    q;

  always_ff @(posedge clk) begin
    if (rst) begin
      prod_valid <= 1'b0;
    end else begin
      prod_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    prod      <= PROD_W'(acc) * PROD_W'($signed({1'b0, gain}));
    prod_last <= last;
  end

  assign rounded = prod + PROD_W'(128);
  assign q       = rounded[PROD_W-1:8];

  always_comb begin
    out_item.last = prod_last;
    if (q[Q_W-1:VALUE_W-1] == '0 || q[Q_W-1:VALUE_W-1] == '1) begin
      out_item.value = q[VALUE_W-1:0];
    end else if (q[Q_W-1]) begin
      out_item.value = {1'b1, {(VALUE_W-1){1'b0}}};
    end else begin
      out_item.value = {1'b0, {(VALUE_W-1){1'b1}}};
    end
  end

  assign out_valid = prod_valid;
  assign busy      = prod_valid;

endmodule

`default_nettype wire

FILE: design/zpola_outq.sv
`default_nettype none

// small result queue; the top reserves its space before a pull is taken
module zpola_outq
  import zpola_pkg::*;
(
  input  wire logic         clk,
  input  wire logic         rst,
  input  wire logic         push,
  input  wire res_item_t    push_item,
  output logic              res_valid,
  input  wire logic         res_ready,
  output res_item_t         res_item,
  output logic [OUTQ_CW-1:0] count
);

  res_item_t          slots [OUTQ_DEPTH];
  logic [OUTQ_AW-1:0] wr_ptr;
  logic [OUTQ_AW-1:0] rd_ptr;
  logic               pop;

  assign res_valid = (count != '0);
  assign res_item  = slots[rd_ptr];
  assign pop       = res_valid && res_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= wr_ptr + 1'b1;
      end
      if (pop) begin
        rd_ptr <= rd_ptr + 1'b1;
      end
      count <= count + OUTQ_CW'(push) - OUTQ_CW'(pop);
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      slots[wr_ptr] <= push_item;
    end
  end

endmodule

`default_nettype wire

FILE: design/zero_phase_overlap_add.sv
`default_nettype none

// channel   | handshake            | payload
// ----------+----------------------+------------------------------------
// cmd       | cmd_valid/cmd_ready  | cmd_item: command, sample
// res       | res_valid/res_ready  | res_item: value, last
// cfg       | cfg_we (no wait)     | cfg_index, cfg_data
//
// one item per cycle while cmd_ready is high; a push writes its store entry in the
// cycle after it is taken, a pull's result passes through the registered store read,
// the gain multiplier register and the result queue
// after reset a clearing pass runs over the whole store and
// cmd_ready stays low through it
// a stalled res side holds up to four results, then cmd_ready drops
module zero_phase_overlap_add
  import zpola_pkg::*;
#(
  parameter int FRAME_MAX = 2048
) (
  input  wire logic              clk,
  input  wire logic              rst,
  input  wire logic              cmd_valid,
  output logic                   cmd_ready,
  input  wire cmd_item_t         cmd_item,
  output logic                   res_valid,
  input  wire logic              res_ready,
  output res_item_t              res_item,
  input  wire logic              cfg_we,
  input  wire logic [CFG_IW-1:0] cfg_index,
  input  wire logic [CFG_W-1:0]  cfg_data
);

  localparam int AW = $clog2(FRAME_MAX);
  // wide enough for base + hop + position and for the raw register values
  localparam int NW = (AW + 2 > LEN_W) ? AW + 2 : LEN_W;

  // configuration registers
  logic [LEN_W-1:0]  frame_size;
  logic [LEN_W-1:0]  hop_size;
  logic [GAIN_W-1:0] norm_gain;

  // sequencing state
  logic [AW-1:0] base_pointer;
  logic [AW-1:0] sample_index;
  logic [AW-1:0] pull_index;

  // front-end decode
  logic          accept;
  logic [NW-1:0] eff_f;
  logic [NW-1:0] eff_h;
  logic [NW-1:0] half;
  logic [NW-1:0] j;
  logic [NW-1:0] pos;
  logic          tail;
  logic [NW-1:0] push_sum;
  logic [NW-1:0] push_sum_a;
  logic [NW-1:0] push_idx;
  logic          frame_done;
  logic [NW-1:0] base_sum;
  logic [NW-1:0] base_idx;
  logic [NW-1:0] k;
  logic [NW-1:0] pull_sum;
  logic [NW-1:0] pull_idx;
  logic          pull_last;
  logic [AW-1:0] rd_addr;

  // store stage
  logic                       s1_valid;
  logic                       s1_cmd;
  logic signed [SAMPLE_W-1:0] s1_sample;
  logic [AW-1:0]              s1_addr;
  logic                       s1_tail;
  logic                       s1_last;
  logic signed [ACC_W-1:0]    rd_data;
  logic signed [ACC_W-1:0]    acc_old;
  logic signed [ACC_W:0]      acc_sum;
  logic signed [ACC_W-1:0]    acc_new;
  logic                       wr_en;
  logic                       s1_pull;

  logic                  store_busy;
  logic                  scale_busy;
  logic                  scale_valid;
  res_item_t             scale_item;
  logic [OUTQ_CW-1:0]    q_count;
  logic [OUTQ_CW-1:0]    pending;

  // register writes: write only while idle; the block itself does not enforce it
  always_ff @(posedge clk) begin
    if (rst) begin
      frame_size <= LEN_W'(1024);
      hop_size   <= LEN_W'(256);
      norm_gain  <= GAIN_W'(256);
    end else if (cfg_we) begin
      unique case (cfg_index)
        REG_FRAME_SIZE: frame_size <= cfg_data[LEN_W-1:0];
        REG_HOP_SIZE:   hop_size   <= cfg_data[LEN_W-1:0];
        REG_NORM_GAIN:  norm_gain  <= cfg_data;
        default: ;
      endcase
    end
  end

  // clamp frame to [2, FRAME_MAX] and hop to [1, frame]
  always_comb begin
    if (NW'(frame_size) < NW'(2)) begin
      eff_f = NW'(2);
    end else if (NW'(frame_size) > NW'(FRAME_MAX)) begin
      eff_f = NW'(FRAME_MAX);
    end else begin
      eff_f = NW'(frame_size);
    end
    if (NW'(hop_size) < NW'(1)) begin
      eff_h = NW'(1);
    end else if (NW'(hop_size) > eff_f) begin
      eff_h = eff_f;
    end else begin
      eff_h = NW'(hop_size);
    end
  end

  // push: swap halves, then place after the hop into the circular store
  always_comb begin
    half = eff_f >> 1;
    // frame shrunk under us: this sample closes the frame
    j    = (NW'(sample_index) >= eff_f) ? eff_f - NW'(1) : NW'(sample_index);
    pos  = (j >= half) ? j - half : j + (eff_f - half);
    tail = (pos >= eff_f - eff_h);
    frame_done = (j == eff_f - NW'(1));

    push_sum   = NW'(base_pointer) + eff_h + pos;
    push_sum_a = (push_sum >= NW'(2 * FRAME_MAX)) ? push_sum - NW'(2 * FRAME_MAX)
                                                  : push_sum;
    push_idx   = (push_sum_a >= NW'(FRAME_MAX)) ? push_sum_a - NW'(FRAME_MAX)
                                                : push_sum_a;

    base_sum = NW'(base_pointer) + eff_h;
    base_idx = (base_sum >= NW'(FRAME_MAX)) ? base_sum - NW'(FRAME_MAX) : base_sum;
  end

  // pull: next hop position of the last finished frame
  always_comb begin
    k         = (NW'(pull_index) >= eff_h) ? '0 : NW'(pull_index);
    pull_sum  = NW'(base_pointer) + k;
    pull_idx  = (pull_sum >= NW'(FRAME_MAX)) ? pull_sum - NW'(FRAME_MAX) : pull_sum;
    pull_last = (k == eff_h - NW'(1));
  end

  assign rd_addr = (cmd_item.command == CMD_PULL) ? pull_idx[AW-1:0] : push_idx[AW-1:0];

  // room in the result queue for everything still in flight
  assign s1_pull   = s1_valid && (s1_cmd == CMD_PULL);
  assign pending   = q_count + OUTQ_CW'(s1_pull) + OUTQ_CW'(scale_busy);
  assign cmd_ready = !store_busy && (pending < OUTQ_CW'(OUTQ_DEPTH));
  assign accept    = cmd_valid && cmd_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      base_pointer <= '0;
      sample_index <= '0;
      pull_index   <= '0;
    end else if (accept) begin
      if (cmd_item.command == CMD_PULL) begin
        pull_index <= pull_last ? '0 : AW'(k + NW'(1));
      end else if (frame_done) begin
        base_pointer <= base_idx[AW-1:0];
        sample_index <= '0;
        pull_index   <= '0;
      end else begin
        sample_index <= AW'(j + NW'(1));
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else begin
      s1_valid <= accept;
    end
  end

  always_ff @(posedge clk) begin
    s1_cmd    <= cmd_item.command;
    s1_sample <= cmd_item.sample;
    s1_addr   <= rd_addr;
    s1_tail   <= tail;
    s1_last   <= pull_last;
  end

  // read-modify-write; the newest hop tail starts from zero
  assign acc_old = s1_tail ? '0 : rd_data;
  assign acc_sum = (ACC_W + 1)'(acc_old) + (ACC_W + 1)'(s1_sample);

  always_comb begin
    if (acc_sum[ACC_W] == acc_sum[ACC_W-1]) begin
      acc_new = acc_sum[ACC_W-1:0];
    end else if (acc_sum[ACC_W]) begin
      acc_new = {1'b1, {(ACC_W-1){1'b0}}};
    end else begin
      acc_new = {1'b0, {(ACC_W-1){1'b1}}};
    end
  end

  assign wr_en = s1_valid && (s1_cmd == CMD_PUSH);

  zpola_store #(
    .FRAME_MAX (FRAME_MAX)
  ) u_store (
    .clk     (clk),
    .rst     (rst),
    .busy    (store_busy),
    .rd_addr (rd_addr),
    .wr_en   (wr_en),
    .wr_addr (s1_addr),
    .wr_data (acc_new),
    .rd_data (rd_data)
  );

  zpola_scale u_scale (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (s1_pull),
    .acc       (rd_data),
    .gain      (norm_gain),
    .last      (s1_last),
    .busy      (scale_busy),
    .out_valid (scale_valid),
    .out_item  (scale_item)
  );

  zpola_outq u_outq (
    .clk       (clk),
    .rst       (rst),
    .push      (scale_valid),
    .push_item (scale_item),
    .res_valid (res_valid),
    .res_ready (res_ready),
    .res_item  (res_item),
    .count     (q_count)
  );

endmodule

`default_nettype wire

FILE: design/zpola_check.sv
`default_nettype none

module zpola_check
  import zpola_pkg::*;
(
  input wire logic      clk,
  input wire logic      rst,
  input wire logic      cmd_valid,
  input wire logic      cmd_ready,
  input wire cmd_item_t cmd_item,
  input wire logic      res_valid,
  input wire logic      res_ready,
  input wire res_item_t res_item
);

  // a waiting result holds
  a_res_hold: assert property (@(posedge clk) disable iff (rst)
    res_valid && !res_ready |=> res_valid && $stable(res_item))
    else $error("result changed while stalled");

  // clearing pass keeps the command side closed right after reset
  a_clear_closed: assert property (@(posedge clk)
    rst |=> !cmd_ready)
    else $error("command taken during store clear");

  // nothing comes out straight after reset
  a_no_stale: assert property (@(posedge clk)
    rst |=> !res_valid)
    else $error("result shown after reset");

  // a result from an empty queue comes from a pull that passed the store read, multiplier and queue
  a_pull_origin: assert property (@(posedge clk) disable iff (rst)
    $rose(res_valid) |->
      $past(cmd_valid && cmd_ready && (cmd_item.command == CMD_PULL), 3))
    else $error("result without a matching pull");

endmodule

bind zero_phase_overlap_add zpola_check u_check (.*);

`default_nettype wire

FILE: tb/tb.sv
`default_nettype none

module tb;
  import zpola_pkg::*;

  // store depth of the block under test
  localparam int STORE_DEPTH = 2048;

  // saturation bounds of the store and of the output value
  localparam int ACC_HI = (1 << (ACC_W - 1)) - 1;
  localparam int ACC_LO = -(1 << (ACC_W - 1));
  localparam longint OUT_HI = (64'sd1 <<< (VALUE_W - 1)) - 1;
  localparam longint OUT_LO = -(64'sd1 <<< (VALUE_W - 1));

  // index that maps to no register, writes to it are ignored
  localparam logic [CFG_IW-1:0] REG_UNUSED = 2'd3;

  // cycles the pipeline may still be busy after the last result
  localparam int SETTLE_CYCLES = 8;
  // length of the forced stall on the result side
  localparam int HOLD_CYCLES = 80;
  // watchdog, in time units (two per cycle)
  localparam int WATCHDOG = 800000;

  // overlap-add predictor plus the queue of pull results still owed
  class overlap_add_sb;
    int acc_store[STORE_DEPTH];
    int unsigned base_ptr;
    int unsigned next_sample;
    int unsigned next_pull;
    int unsigned frame_reg;
    int unsigned hop_reg;
    int unsigned gain_reg;
    res_item_t pull_results_q[$];
    int errors;

    function new();
      foreach (acc_store[i]) acc_store[i] = 0;
      base_ptr = 0;
      next_sample = 0;
      next_pull = 0;
      frame_reg = 1024;
      hop_reg = 256;
      gain_reg = 256;
      errors = 0;
    endfunction

    function void set_reg(logic [CFG_IW-1:0] idx, logic [CFG_W-1:0] d);
      case (idx)
        REG_FRAME_SIZE: frame_reg = d[LEN_W-1:0];
        REG_HOP_SIZE:   hop_reg = d[LEN_W-1:0];
        REG_NORM_GAIN:  gain_reg = d[GAIN_W-1:0];
        default: ;
      endcase
    endfunction

    // update the store on a push, queue the expected value on a pull
    function void take_cmd(cmd_item_t it);
      int unsigned f, h, half, j, pos, slot, k;
      int old, sum;
      longint prod;
      res_item_t r;
      f = frame_reg;
      if (f < 2) f = 2;
      if (f > STORE_DEPTH) f = STORE_DEPTH;
      h = hop_reg;
      if (h < 1) h = 1;
      if (h > f) h = f;
      if (it.command == CMD_PUSH) begin
        j = next_sample;
        if (j >= f) j = f - 1;
        half = f / 2;
        pos = (j >= half) ? (j - half) : (j + (f - half));
        slot = (base_ptr + h + pos) % STORE_DEPTH;
        old = (pos >= f - h) ? 0 : acc_store[slot];
        sum = old + int'($signed(it.sample));
        if (sum > ACC_HI) sum = ACC_HI;
        if (sum < ACC_LO) sum = ACC_LO;
        acc_store[slot] = sum;
        if (j == f - 1) begin
          base_ptr = (base_ptr + h) % STORE_DEPTH;
          next_sample = 0;
          next_pull = 0;
        end else begin
          next_sample = j + 1;
        end
      end else begin
        k = next_pull;
        if (k >= h) k = 0;
        prod = longint'(acc_store[(base_ptr + k) % STORE_DEPTH]) * longint'(gain_reg) + 128;
        prod = prod >>> 8;
        if (prod > OUT_HI) prod = OUT_HI;
        if (prod < OUT_LO) prod = OUT_LO;
        r.value = prod[VALUE_W-1:0];
        r.last = (k == h - 1);
        next_pull = r.last ? 0 : k + 1;
        pull_results_q.push_back(r);
      end
    endfunction

    function void check_res(res_item_t got);
      res_item_t want;
      if (pull_results_q.size() == 0) begin
        $error("unexpected result: value %0d last %0d", got.value, got.last);
        errors++;
        return;
      end
      want = pull_results_q.pop_front();
      if (got.value !== want.value) begin
        $error("value: expected %0d, actual %0d", want.value, got.value);
        errors++;
      end
      if (got.last !== want.last) begin
        $error("last: expected %0d, actual %0d", want.last, got.last);
        errors++;
      end
    endfunction

    function int pending();
      return pull_results_q.size();
    endfunction
  endclass

  logic clk = 1'b0;
  logic rst;
  logic cmd_valid;
  logic cmd_ready;
  cmd_item_t cmd_item;
  logic res_valid;
  logic res_ready;
  res_item_t res_item;
  logic cfg_we;
  logic [CFG_IW-1:0] cfg_index;
  logic [CFG_W-1:0] cfg_data;

  overlap_add_sb sb = new();

  // no idling in the closing part of the run
  bit quiet = 1'b0;
  // handshake between sender and receiver for the long stall
  bit hold_req = 1'b0;
  bit hold_on = 1'b0;

  always #1 clk = ~clk;

  zero_phase_overlap_add #(
    .FRAME_MAX(STORE_DEPTH)
  ) u_top (
    .clk(clk),
    .rst(rst),
    .cmd_valid(cmd_valid),
    .cmd_ready(cmd_ready),
    .cmd_item(cmd_item),
    .res_valid(res_valid),
    .res_ready(res_ready),
    .res_item(res_item),
    .cfg_we(cfg_we),
    .cfg_index(cfg_index),
    .cfg_data(cfg_data)
  );

  // every accepted result goes against the oldest expectation
  always @(posedge clk) begin
    if (!rst && res_valid && res_ready) sb.check_res(res_item);
  end

  // result side: random ready bursts, a long stall on request
  initial begin : res_side
    int unsigned span;
    bit want;
    res_ready = 1'b0;
    @(posedge clk);
    forever begin
      if (hold_req) begin
        res_ready <= 1'b0;
        hold_on = 1'b1;
        repeat (HOLD_CYCLES) @(posedge clk);
        hold_req = 1'b0;
        hold_on = 1'b0;
      end else begin
        want = quiet || ($urandom_range(0, 3) != 0);
        span = quiet ? 1 : (want ? $urandom_range(1, 20) : $urandom_range(1, 13));
        res_ready <= want;
        repeat (span) @(posedge clk);
      end
    end
  end

  // offer one item, maybe after an idle burst, and hold it until taken
  task automatic send_item(cmd_item_t it);
    if (!quiet && $urandom_range(0, 4) == 0) begin
      cmd_valid <= 1'b0;
      repeat ($urandom_range(1, 13)) @(posedge clk);
    end
    cmd_valid <= 1'b1;
    cmd_item <= it;
    do @(posedge clk); while (!cmd_ready);
    sb.take_cmd(it);
  endtask

  task automatic push_sample(logic signed [SAMPLE_W-1:0] s);
    cmd_item_t it;
    it.command = CMD_PUSH;
    it.sample = s;
    send_item(it);
  endtask

  // pulls carry random sample bits, the block must ignore them
  task automatic pull_one();
    cmd_item_t it;
    it.command = CMD_PULL;
    it.sample = 16'($urandom_range(0, 16'hFFFF));
    send_item(it);
  endtask

  // stop offering, wait for every owed result, then let the pipe empty
  task automatic settle();
    cmd_valid <= 1'b0;
    while (sb.pending() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic write_cfg(logic [CFG_IW-1:0] idx, logic [CFG_W-1:0] d);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_data <= d;
    @(posedge clk);
    sb.set_reg(idx, d);
  endtask

  task automatic end_cfg();
    cfg_we <= 1'b0;
    @(posedge clk);
  endtask

  // frame and hop carry random bits above the 12-bit field
  task automatic set_all(int unsigned f, int unsigned h, int unsigned g);
    write_cfg(REG_FRAME_SIZE, {4'($urandom_range(0, 15)), 12'(f)});
    write_cfg(REG_HOP_SIZE, {4'($urandom_range(0, 15)), 12'(h)});
    write_cfg(REG_NORM_GAIN, 16'(g));
    end_cfg();
  endtask

  // random item stream; sat forces one extreme sample sign
  task automatic run_phase(int n, int pull_pct, int push_only, int sat);
    cmd_item_t it;
    for (int i = 0; i < n; i++) begin
      if (i >= push_only && $urandom_range(0, 99) < pull_pct) it.command = CMD_PULL;
      else it.command = CMD_PUSH;
      if (sat > 0) it.sample = 16'sh7FFF;
      else if (sat < 0) it.sample = 16'sh8000;
      else begin
        case ($urandom_range(0, 7))
          0: it.sample = 16'sh7FFF;
          1: it.sample = 16'sh8000;
          2: it.sample = 16'sh0000;
          default: it.sample = 16'($urandom_range(0, 16'hFFFF));
        endcase
      end
      send_item(it);
    end
  endtask

  initial begin : stimulus
    int unsigned f, h, g;
    rst = 1'b1;
    cmd_valid = 1'b0;
    cmd_item = '0;
    cfg_we = 1'b0;
    cfg_index = REG_FRAME_SIZE;
    cfg_data = '0;
    repeat (10) @(posedge clk);
    rst <= 1'b0;

    // reads of the cleared store before any frame, reset settings
    pull_one();
    pull_one();
    settle();

    // tiny frame: extremes, a completed frame, hop wrap of the pull index
    write_cfg(REG_FRAME_SIZE, 16'd4);
    write_cfg(REG_HOP_SIZE, 16'd2);
    write_cfg(REG_UNUSED, 16'hFFFF);
    end_cfg();
    push_sample(16'sh7FFF);
    push_sample(16'sh8000);
    push_sample(16'sh0001);
    push_sample(16'shFFFF);
    pull_one();
    pull_one();
    pull_one();
    push_sample(16'sh7FFF);
    push_sample(16'sh7FFF);
    push_sample(16'sh0000);
    push_sample(16'sh8000);
    pull_one();
    pull_one();
    settle();

    // frame and hop below range get clamped up, largest gain
    set_all(0, 0, 16'hFFFF);
    push_sample(16'sh7FFF);
    push_sample(16'sh7FFF);
    pull_one();
    pull_one();
    settle();

    // frame and hop above range clamp to the store size, zero gain
    set_all(12'hFFF, 12'hFFF, 0);
    pull_one();
    pull_one();
    push_sample(16'sh1234);
    settle();

    // frame over half the store with full hop: frame plus hop exceed the
    // store by 152 entries, so 152 of the tail writes land on the entries
    // that pulls are reading
    set_all(1100, 1100, $urandom_range(0, 16'hFFFF));
    run_phase(630, 50, 530, 0);
    settle();

    // unit hop, long overlap: store and output saturate, both signs;
    // the frame shrinks under a large pending sample index here too
    set_all(17, 1, 16'hFFFF);
    run_phase(340, 12, 0, 1);
    settle();
    set_all(17, 1, 16'hFFFF);
    run_phase(340, 12, 0, -1);
    settle();

    for (int p = 0; p < 6; p++) begin
      f = $urandom_range(2, 40);
      h = $urandom_range(1, f);
      g = $urandom_range(0, 16'hFFFF);
      case (p)
        1: begin
          f = 2;
          h = 12'hFFF;
          g = 16'hFFFF;
        end
        3: begin
          f = 1;
          h = 0;
          g = 128;
        end
        4: begin
          f = $urandom_range(20, 40);
          h = f;
        end
        5: quiet = 1'b1;
        default: ;
      endcase
      set_all(f, h, g);
      if (p == 0) begin
        // result side stalls while pulls keep coming, the block fills up
        hold_req = 1'b1;
        wait (hold_on);
        repeat (16) pull_one();
      end
      if (p == 2) begin
        run_phase(25, $urandom_range(20, 70), 0, 0);
        // sender waits for every owed result before going on
        cmd_valid <= 1'b0;
        while (sb.pending() != 0) @(posedge clk);
        run_phase(25, $urandom_range(20, 70), 0, 0);
      end else begin
        run_phase(50, $urandom_range(20, 70), 0, 0);
      end
      settle();
    end

    repeat (20) @(posedge clk);
    if (sb.errors == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end

  // watchdog against a hung handshake
  initial begin
    #(WATCHDOG);
    $display("Mismatches found");
    $finish;
  end

endmodule

`default_nettype wire
